FILE: src/skc_pkg.sv
// ----------------------------------------------------------------------------
// skc_pkg
// Shared types, constants and character helpers of the string key comparator.
// ----------------------------------------------------------------------------
package skc_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned FieldW = 11;
  localparam int unsigned DiffW  = 9;
  localparam int unsigned CfgIdxW = 4;

  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic [CharW-1:0] CharNul   = 8'h00;
  localparam logic [CharW-1:0] CaseDelta = 8'h20;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFoldCase  = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgDictOrder = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgFieldStart = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgFieldEnd  = 4'd3;

  typedef enum logic [1:0] {
    ACT_LOAD_A,
    ACT_LOAD_B,
    ACT_COMPARE
  } action_e;

  typedef struct packed {
    action_e          action;
    logic [CharW-1:0] char_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [DiffW-1:0] difference;
    logic                    overflowed;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_START,
    ST_REQ_A,
    ST_GET_A,
    ST_REQ_B,
    ST_GET_B,
    ST_CHECK,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic limit;
    logic start;
    logic rd_a;
    logic rd_b;
    logic skip_a;
    logic skip_b;
    logic take_a;
    logic take_b;
    logic end_a;
    logic end_b;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic a_more;
    logic b_more;
    logic a_skip;
    logic b_skip;
    logic keep_going;
    logic out_busy;
  } status_t;

  function automatic logic is_kept(input logic [CharW-1:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]}) || (c == CharSpace);
  endfunction

  function automatic logic [CharW-1:0] fold_char(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c inside {[8'h41:8'h5a]}) begin
      r = c + CaseDelta;
    end
    return r;
  endfunction

endpackage

FILE: src/skc_ram.sv
// ----------------------------------------------------------------------------
// skc_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module skc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/skc_datapath.sv
// ----------------------------------------------------------------------------
// skc_datapath
// Key stores, lengths, window limits, walk pointers and the result register.
// ----------------------------------------------------------------------------
module skc_datapath #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  skc_pkg::cmd_t                  cmd_i,
  output skc_pkg::status_t               status_o,
  input  logic [skc_pkg::CharW-1:0]      char_i,
  input  logic                           cfg_valid_i,
  input  logic [skc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [skc_pkg::FieldW-1:0]     cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output skc_pkg::out_item_t             out_data_o
);

  localparam int unsigned LenW  = $clog2(MAX_LEN + 1);
  localparam int unsigned AddrW = $clog2(MAX_LEN);
  localparam int unsigned CmpW  = (LenW > skc_pkg::FieldW) ? LenW : skc_pkg::FieldW;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_LEN);

  logic                        fold_q, dict_q;
  logic [skc_pkg::FieldW-1:0]  fstart_q, fend_q;
  logic [LenW-1:0]             len_a_q, len_b_q, eff_a_q, eff_b_q;
  logic                        term_a_q, term_b_q, dropped_q, out_valid_q;
  logic [LenW-1:0]             lim_a_q, lim_b_q, ptr_a_q, ptr_b_q;
  logic [skc_pkg::CharW-1:0]   ch_a_q, ch_b_q;
  skc_pkg::out_item_t          out_q;

  logic                        we_a, we_b, room_a, room_b;
  logic [AddrW-1:0]            addr_a, addr_b;
  logic [skc_pkg::CharW-1:0]   rdata_a, rdata_b;
  logic [LenW-1:0]             lim_a_d, lim_b_d, start_a, start_b;

  assign room_a = len_a_q < MaxLen;
  assign room_b = len_b_q < MaxLen;
  assign we_a   = cmd_i.wr_a && room_a;
  assign we_b   = cmd_i.wr_b && room_b;
  assign addr_a = cmd_i.rd_a ? ptr_a_q[AddrW-1:0] : len_a_q[AddrW-1:0];
  assign addr_b = cmd_i.rd_b ? ptr_b_q[AddrW-1:0] : len_b_q[AddrW-1:0];

  skc_ram #(.Width(skc_pkg::CharW), .Depth(MAX_LEN)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .addr_i  (addr_a),
    .wdata_i (char_i),
    .rdata_o (rdata_a)
  );

  skc_ram #(.Width(skc_pkg::CharW), .Depth(MAX_LEN)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .addr_i  (addr_b),
    .wdata_i (char_i),
    .rdata_o (rdata_b)
  );

  // window end: key length up to any zero byte, or field end when set and shorter
  always_comb begin
    lim_a_d = eff_a_q;
    lim_b_d = eff_b_q;
    if (fend_q != '0 && CmpW'(fend_q) < CmpW'(eff_a_q)) begin
      lim_a_d = LenW'(fend_q);
    end
    if (fend_q != '0 && CmpW'(fend_q) < CmpW'(eff_b_q)) begin
      lim_b_d = LenW'(fend_q);
    end
    start_a = (CmpW'(fstart_q) < CmpW'(lim_a_q)) ? LenW'(fstart_q) : lim_a_q;
    start_b = (CmpW'(fstart_q) < CmpW'(lim_b_q)) ? LenW'(fstart_q) : lim_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q      <= 1'b0;
      dict_q      <= 1'b0;
      fstart_q    <= '0;
      fend_q      <= '0;
      len_a_q     <= '0;
      len_b_q     <= '0;
      eff_a_q     <= '0;
      eff_b_q     <= '0;
      term_a_q    <= 1'b0;
      term_b_q    <= 1'b0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          skc_pkg::CfgFoldCase:   fold_q   <= cfg_data_i[0];
          skc_pkg::CfgDictOrder:  dict_q   <= cfg_data_i[0];
          skc_pkg::CfgFieldStart: fstart_q <= cfg_data_i;
          skc_pkg::CfgFieldEnd:   fend_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (we_a) begin
        len_a_q <= len_a_q + 1'b1;
        // a zero byte terminates the key
        if (char_i == skc_pkg::CharNul) begin
          term_a_q <= 1'b1;
        end else if (!term_a_q) begin
          eff_a_q <= eff_a_q + 1'b1;
        end
      end
      if (we_b) begin
        len_b_q <= len_b_q + 1'b1;
        if (char_i == skc_pkg::CharNul) begin
          term_b_q <= 1'b1;
        end else if (!term_b_q) begin
          eff_b_q <= eff_b_q + 1'b1;
        end
      end
      if ((cmd_i.wr_a && !room_a) || (cmd_i.wr_b && !room_b)) begin
        dropped_q <= 1'b1;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        len_a_q     <= '0;
        len_b_q     <= '0;
        eff_a_q     <= '0;
        eff_b_q     <= '0;
        term_a_q    <= 1'b0;
        term_b_q    <= 1'b0;
        dropped_q   <= 1'b0;
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.limit) begin
      lim_a_q <= lim_a_d;
      lim_b_q <= lim_b_d;
    end
    if (cmd_i.start) begin
      ptr_a_q <= start_a;
      ptr_b_q <= start_b;
    end
    if (cmd_i.skip_a || cmd_i.take_a) begin
      ptr_a_q <= ptr_a_q + 1'b1;
    end
    if (cmd_i.skip_b || cmd_i.take_b) begin
      ptr_b_q <= ptr_b_q + 1'b1;
    end
    if (cmd_i.take_a) begin
      ch_a_q <= fold_q ? skc_pkg::fold_char(rdata_a) : rdata_a;
    end else if (cmd_i.end_a) begin
      ch_a_q <= skc_pkg::CharNul;
    end
    if (cmd_i.take_b) begin
      ch_b_q <= fold_q ? skc_pkg::fold_char(rdata_b) : rdata_b;
    end else if (cmd_i.end_b) begin
      ch_b_q <= skc_pkg::CharNul;
    end
    if (cmd_i.finish) begin
      out_q.difference <= $signed({1'b0, ch_a_q}) - $signed({1'b0, ch_b_q});
      out_q.overflowed <= dropped_q;
    end
  end

  assign status_o.a_more     = ptr_a_q < lim_a_q;
  assign status_o.b_more     = ptr_b_q < lim_b_q;
  assign status_o.a_skip     = dict_q && !skc_pkg::is_kept(rdata_a);
  assign status_o.b_skip     = dict_q && !skc_pkg::is_kept(rdata_b);
  assign status_o.keep_going = (ch_a_q == ch_b_q) && (ch_a_q != skc_pkg::CharNul);
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: src/skc_ctrl.sv
// ----------------------------------------------------------------------------
// skc_ctrl
// Sequencer for loads and the character walk of a compare.
// ----------------------------------------------------------------------------
module skc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  skc_pkg::action_e action_i,
  input  skc_pkg::status_t status_i,
  output skc_pkg::cmd_t    cmd_o
);

  skc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      skc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (action_i)
            skc_pkg::ACT_LOAD_A:  cmd_o.wr_a = 1'b1;
            skc_pkg::ACT_LOAD_B:  cmd_o.wr_b = 1'b1;
            skc_pkg::ACT_COMPARE: state_d = skc_pkg::ST_LIMIT;
            default: ;
          endcase
        end
      end
      skc_pkg::ST_LIMIT: begin
        cmd_o.limit = 1'b1;
        state_d     = skc_pkg::ST_START;
      end
      skc_pkg::ST_START: begin
        cmd_o.start = 1'b1;
        state_d     = skc_pkg::ST_REQ_A;
      end
      skc_pkg::ST_REQ_A: begin
        if (status_i.a_more) begin
          cmd_o.rd_a = 1'b1;
          state_d    = skc_pkg::ST_GET_A;
        end else begin
          cmd_o.end_a = 1'b1;
          state_d     = skc_pkg::ST_REQ_B;
        end
      end
      skc_pkg::ST_GET_A: begin
        if (status_i.a_skip) begin
          cmd_o.skip_a = 1'b1;
          state_d      = skc_pkg::ST_REQ_A;
        end else begin
          cmd_o.take_a = 1'b1;
          state_d      = skc_pkg::ST_REQ_B;
        end
      end
      skc_pkg::ST_REQ_B: begin
        if (status_i.b_more) begin
          cmd_o.rd_b = 1'b1;
          state_d    = skc_pkg::ST_GET_B;
        end else begin
          cmd_o.end_b = 1'b1;
          state_d     = skc_pkg::ST_CHECK;
        end
      end
      skc_pkg::ST_GET_B: begin
        if (status_i.b_skip) begin
          cmd_o.skip_b = 1'b1;
          state_d      = skc_pkg::ST_REQ_B;
        end else begin
          cmd_o.take_b = 1'b1;
          state_d      = skc_pkg::ST_CHECK;
        end
      end
      skc_pkg::ST_CHECK: begin
        state_d = status_i.keep_going ? skc_pkg::ST_REQ_A : skc_pkg::ST_DONE;
      end
      skc_pkg::ST_DONE: begin
        // wait for the result slot to free up
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = skc_pkg::ST_IDLE;
        end
      end
      default: state_d = skc_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: src/string_key_comparator_core.sv
// Each load writes one byte into a key store RAM; while no compare runs, one byte
// enters per cycle unless that store is full. A compare latches the window limits,
// then the start pointers, then per pair reads key A then key B (a key at its end is
// not read, skips passed over), checks the pair and finishes once the result is free.
// The walk is set by the single-port key RAMs, read one character at a time.
// Reset clears lengths, overflow flag, config and control; key RAMs are not cleared.
// ----------------------------------------------------------------------------
// string_key_comparator_core
// Sort-key comparator over two loaded byte strings with field window,
// case folding and dictionary order.
// ----------------------------------------------------------------------------
module string_key_comparator_core #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  skc_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output skc_pkg::out_item_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [skc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [skc_pkg::FieldW-1:0]  cfg_data_i
);

  skc_pkg::cmd_t    cmd;
  skc_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  skc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (in_data_i.action),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  skc_datapath #(.MAX_LEN(MAX_LEN)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .char_i      (in_data_i.char_byte),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: bench/string_key_comparator_core_test.sv
// ----------------------------------------------------------------------------
// string_key_comparator_core_test
// Self-checking bench for the sort-key comparator: loads random key pairs,
// compares them under changing window, folding and dictionary settings, and
// checks each difference and overflow flag against an in-bench key model.
// ----------------------------------------------------------------------------
module string_key_comparator_core_test;

  localparam int unsigned KeyCap = 1024;
  localparam int unsigned RandomItems = 850;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned LongHold = 500;
  localparam longint unsigned RunLimit = 64'd24_000_000;

  localparam skc_pkg::action_e ActIgnored = skc_pkg::action_e'(2'd3);
  localparam logic [skc_pkg::CfgIdxW-1:0] CfgUnused = 4'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  skc_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  skc_pkg::out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [skc_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [skc_pkg::FieldW-1:0] cfg_data_i = '0;

  string_key_comparator_core #(
    .MAX_LEN(KeyCap)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // key model state
  logic [skc_pkg::CharW-1:0] key_a_bytes [KeyCap];
  logic [skc_pkg::CharW-1:0] key_b_bytes [KeyCap];
  int unsigned len_a = 0;
  int unsigned len_b = 0;
  logic dropped = 1'b0;
  logic cfg_fold = 1'b0;
  logic cfg_dict = 1'b0;
  int unsigned cfg_start = 0;
  int unsigned cfg_end = 0;

  skc_pkg::out_item_t awaited_diffs [$];
  skc_pkg::in_item_t key_traffic [$];

  bit in_fire = 1'b0;
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned key_items = 0;
  int unsigned ignored_items = 0;
  int unsigned results_checked = 0;
  int unsigned overflow_results = 0;
  int unsigned cfg_writes = 0;
  int unsigned fail_count = 0;

  int unsigned tx_gap = 0;
  bit tx_calm = 1'b0;
  int unsigned rx_hold = 0;
  bit rx_calm = 1'b0;
  int unsigned next_long_hold = 30;

  function automatic bit kept_char(logic [skc_pkg::CharW-1:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
           (c >= "A" && c <= "Z") || c == skc_pkg::CharSpace;
  endfunction

  function automatic logic [skc_pkg::CharW-1:0] stored_byte(bit from_b, int unsigned p);
    return from_b ? key_b_bytes[p] : key_a_bytes[p];
  endfunction

  // a key ends at its length, at a zero byte, or at a nonzero field end
  function automatic int unsigned key_limit(bit from_b);
    int unsigned len;
    int unsigned n;
    len = from_b ? len_b : len_a;
    n = 0;
    while (n < len && stored_byte(from_b, n) != skc_pkg::CharNul) n++;
    if (cfg_end != 0 && cfg_end < n) n = cfg_end;
    return n;
  endfunction

  function automatic logic [skc_pkg::CharW-1:0] walk_char(bit from_b, int unsigned lim,
                                                          inout int unsigned pos);
    logic [skc_pkg::CharW-1:0] c;
    c = skc_pkg::CharNul;
    if (cfg_dict) begin
      while (pos < lim && !kept_char(stored_byte(from_b, pos))) pos++;
    end
    if (pos < lim) begin
      c = stored_byte(from_b, pos);
      pos++;
    end
    if (cfg_fold && c >= "A" && c <= "Z") c = c + skc_pkg::CaseDelta;
    return c;
  endfunction

  function automatic skc_pkg::out_item_t compare_keys();
    int unsigned lim_a;
    int unsigned lim_b;
    int unsigned pa;
    int unsigned pb;
    logic [skc_pkg::CharW-1:0] ca;
    logic [skc_pkg::CharW-1:0] cb;
    int d;
    skc_pkg::out_item_t r;
    lim_a = key_limit(1'b0);
    lim_b = key_limit(1'b1);
    pa = cfg_start < lim_a ? cfg_start : lim_a;
    pb = cfg_start < lim_b ? cfg_start : lim_b;
    do begin
      ca = walk_char(1'b0, lim_a, pa);
      cb = walk_char(1'b1, lim_b, pb);
    end while (ca == cb && ca != skc_pkg::CharNul);
    d = int'(ca) - int'(cb);
    r.difference = d[skc_pkg::DiffW-1:0];
    r.overflowed = dropped;
    return r;
  endfunction

  task automatic absorb_key_item(skc_pkg::in_item_t it);
    case (it.action)
      skc_pkg::ACT_LOAD_A: begin
        if (len_a < KeyCap) begin
          key_a_bytes[len_a] = it.char_byte;
          len_a++;
        end else begin
          dropped = 1'b1;
        end
      end
      skc_pkg::ACT_LOAD_B: begin
        if (len_b < KeyCap) begin
          key_b_bytes[len_b] = it.char_byte;
          len_b++;
        end else begin
          dropped = 1'b1;
        end
      end
      skc_pkg::ACT_COMPARE: begin
        awaited_diffs.push_back(compare_keys());
        len_a = 0;
        len_b = 0;
        dropped = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result(skc_pkg::out_item_t got);
    skc_pkg::out_item_t want;
    results_checked++;
    if (got.overflowed) overflow_results++;
    if (awaited_diffs.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual difference=%0d overflowed=%0b",
               $time, got.difference, got.overflowed);
      fail_count++;
    end else begin
      want = awaited_diffs.pop_front();
      if (got.difference !== want.difference) begin
        $display("%0t: difference mismatch, expected %0d, actual %0d",
                 $time, want.difference, got.difference);
        fail_count++;
      end
      if (got.overflowed !== want.overflowed) begin
        $display("%0t: overflowed mismatch, expected %0b, actual %0b",
                 $time, want.overflowed, got.overflowed);
        fail_count++;
      end
    end
  endtask

  // mostly back to back, sometimes a short gap, rarely a long one
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return 0;
    if (roll < 97) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // monitor: handshakes sampled at the rising edge
  always @(posedge clk_i) begin
    in_fire = in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_writes++;
        case (cfg_index_i)
          skc_pkg::CfgFoldCase:   cfg_fold = cfg_data_i[0];
          skc_pkg::CfgDictOrder:  cfg_dict = cfg_data_i[0];
          skc_pkg::CfgFieldStart: cfg_start = 32'(cfg_data_i);
          skc_pkg::CfgFieldEnd:   cfg_end = 32'(cfg_data_i);
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        items_accepted++;
        absorb_key_item(in_data_i);
      end
      if (out_valid_o && out_ready_i) check_result(out_data_o);
    end
  end

  // driver: one transaction at a time from key_traffic
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (tx_gap > 0) begin
        in_valid_i <= 1'b0;
        tx_gap--;
      end else if (key_traffic.size() != 0) begin
        in_data_i <= key_traffic.pop_front();
        in_valid_i <= 1'b1;
        tx_gap = tx_calm ? 0 : idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    if ($urandom_range(0, 47) == 0) tx_calm = ($urandom_range(0, 2) == 0);
  end

  // receiver: random stalls plus a long hold-off now and then to back up the block
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_ready_i <= 1'b0;
      rx_hold--;
    end else if (results_checked >= next_long_hold) begin
      out_ready_i <= 1'b0;
      rx_hold = LongHold - 1;
      next_long_hold += 400;
    end else if (rx_calm) begin
      out_ready_i <= 1'b1;
    end else begin
      rx_hold = idle_len();
      out_ready_i <= (rx_hold == 0);
      if (rx_hold > 0) rx_hold--;
    end
    if ($urandom_range(0, 47) == 0) rx_calm = ($urandom_range(0, 2) == 0);
  end

  task automatic queue_item(skc_pkg::action_e act, logic [skc_pkg::CharW-1:0] c);
    skc_pkg::in_item_t it;
    it.action = act;
    it.char_byte = c;
    key_traffic.push_back(it);
    items_queued++;
    if (act == ActIgnored) ignored_items++;
    else key_items++;
  endtask

  task automatic write_reg(logic [skc_pkg::CfgIdxW-1:0] idx,
                           logic [skc_pkg::FieldW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_until_idle();
    while (items_accepted != items_queued || awaited_diffs.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [skc_pkg::CharW-1:0] junk_char();
    logic [skc_pkg::CharW-1:0] c;
    do c = 8'($urandom_range(1, 255)); while (kept_char(c));
    return c;
  endfunction

  function automatic logic [skc_pkg::CharW-1:0] random_char();
    int unsigned roll;
    logic [skc_pkg::CharW-1:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 38) c = "a" + 8'($urandom_range(0, 25));
    else if (roll < 56) c = "A" + 8'($urandom_range(0, 25));
    else if (roll < 66) c = "0" + 8'($urandom_range(0, 9));
    else if (roll < 74) c = skc_pkg::CharSpace;
    else if (roll < 86) c = junk_char();
    else if (roll < 96) c = 8'($urandom_range(128, 255));
    else if (roll < 98) c = skc_pkg::CharNul;
    else c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic int unsigned random_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(0, 10);
    if (roll < 95) return $urandom_range(11, 24);
    return $urandom_range(25, 60);
  endfunction

  // key B is mostly a near copy of key A so the walk gets deep
  task automatic queue_key_pair();
    logic [skc_pkg::CharW-1:0] a_chars [$];
    logic [skc_pkg::CharW-1:0] b_chars [$];
    int unsigned ia;
    int unsigned ib;
    bit to_a;
    repeat (random_len()) a_chars.push_back(random_char());
    b_chars = a_chars;
    // rolls not listed keep the copy identical
    case ($urandom_range(0, 6))
      1: begin
        if (b_chars.size() != 0) b_chars[$urandom_range(0, b_chars.size() - 1)] = random_char();
      end
      2: begin
        foreach (b_chars[k]) begin
          if ((b_chars[k] | skc_pkg::CaseDelta) >= "a" &&
              (b_chars[k] | skc_pkg::CaseDelta) <= "z" &&
              $urandom_range(0, 1)) b_chars[k] = b_chars[k] ^ skc_pkg::CaseDelta;
        end
      end
      3: begin
        repeat ($urandom_range(1, 3)) b_chars.insert($urandom_range(0, b_chars.size()), junk_char());
      end
      4: begin
        if (b_chars.size() != 0 && $urandom_range(0, 1)) void'(b_chars.pop_back());
        else b_chars.push_back(random_char());
      end
      5: begin
        b_chars = {};
        repeat (random_len()) b_chars.push_back(random_char());
      end
      default: begin
      end
    endcase
    ia = 0;
    ib = 0;
    while (ia < a_chars.size() || ib < b_chars.size()) begin
      if ($urandom_range(0, 29) == 0) queue_item(ActIgnored, 8'($urandom_range(0, 255)));
      to_a = (ib >= b_chars.size()) || (ia < a_chars.size() && $urandom_range(0, 1));
      if (to_a) begin
        queue_item(skc_pkg::ACT_LOAD_A, a_chars[ia]);
        ia++;
      end else begin
        queue_item(skc_pkg::ACT_LOAD_B, b_chars[ib]);
        ib++;
      end
    end
    queue_item(skc_pkg::ACT_COMPARE, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned random_base;
    int unsigned roll;
    int unsigned fstart;
    int unsigned fend;
    logic [skc_pkg::CharW-1:0] c;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes under reset settings: empty keys, +255, -255, case sensitivity
    queue_item(skc_pkg::ACT_COMPARE, 8'h00);
    queue_item(skc_pkg::ACT_LOAD_A, 8'hff);
    queue_item(skc_pkg::ACT_LOAD_B, skc_pkg::CharNul);
    queue_item(skc_pkg::ACT_COMPARE, 8'hff);
    queue_item(skc_pkg::ACT_LOAD_B, 8'hff);
    queue_item(skc_pkg::ACT_COMPARE, 8'h55);
    queue_item(ActIgnored, 8'ha5);
    queue_item(skc_pkg::ACT_LOAD_A, "A");
    queue_item(skc_pkg::ACT_LOAD_A, "b");
    queue_item(skc_pkg::ACT_LOAD_B, "a");
    queue_item(skc_pkg::ACT_LOAD_B, "B");
    queue_item(skc_pkg::ACT_COMPARE, 8'h00);
    wait_until_idle();

    // folding and skipping, zero byte ending key B early
    write_reg(skc_pkg::CfgFoldCase, 11'd1);
    write_reg(skc_pkg::CfgDictOrder, 11'd1);
    queue_item(skc_pkg::ACT_LOAD_A, "-");
    queue_item(skc_pkg::ACT_LOAD_A, "Q");
    queue_item(skc_pkg::ACT_LOAD_B, "q");
    queue_item(skc_pkg::ACT_LOAD_B, skc_pkg::CharNul);
    queue_item(skc_pkg::ACT_LOAD_B, "z");
    queue_item(skc_pkg::ACT_COMPARE, 8'h00);
    wait_until_idle();

    // window at the far end clamps both keys
    write_reg(skc_pkg::CfgFieldStart, 11'(KeyCap));
    write_reg(skc_pkg::CfgFieldEnd, 11'(KeyCap));
    queue_item(skc_pkg::ACT_LOAD_A, "a");
    queue_item(skc_pkg::ACT_LOAD_B, "b");
    queue_item(skc_pkg::ACT_COMPARE, 8'h00);
    wait_until_idle();

    // start past end
    write_reg(skc_pkg::CfgFieldStart, 11'd2);
    write_reg(skc_pkg::CfgFieldEnd, 11'd1);
    write_reg(CfgUnused, 11'h7ff);
    queue_item(skc_pkg::ACT_LOAD_A, "a");
    queue_item(skc_pkg::ACT_LOAD_A, "b");
    queue_item(skc_pkg::ACT_LOAD_A, "c");
    queue_item(skc_pkg::ACT_LOAD_B, "a");
    queue_item(skc_pkg::ACT_LOAD_B, "b");
    queue_item(skc_pkg::ACT_LOAD_B, "d");
    queue_item(skc_pkg::ACT_COMPARE, 8'h00);
    wait_until_idle();

    // store A overfilled, window near the top of store A, key B short
    write_reg(skc_pkg::CfgFoldCase, 11'd0);
    write_reg(skc_pkg::CfgDictOrder, 11'd0);
    write_reg(skc_pkg::CfgFieldStart, 11'(KeyCap - 2));
    write_reg(skc_pkg::CfgFieldEnd, 11'd0);
    for (int k = 0; k < KeyCap + 2; k++) begin
      c = 8'($urandom_range(1, 255));
      queue_item(skc_pkg::ACT_LOAD_A, c);
      if (k < 3) queue_item(skc_pkg::ACT_LOAD_B, c);
    end
    queue_item(skc_pkg::ACT_COMPARE, 8'h00);
    wait_until_idle();

    random_base = key_items;
    while (key_items < random_base + RandomItems) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) fstart = 0;
      else if (roll < 85) fstart = $urandom_range(1, 4);
      else if (roll < 95) fstart = $urandom_range(5, 12);
      else fstart = $urandom_range(0, 1) ? KeyCap : $urandom_range(0, KeyCap);
      roll = $urandom_range(0, 99);
      if (roll < 50) fend = 0;
      else if (roll < 80) fend = fstart + $urandom_range(1, 8);
      else if (roll < 90) fend = $urandom_range(1, 3);
      else fend = $urandom_range(0, 1) ? KeyCap : $urandom_range(0, KeyCap);
      if (fend > KeyCap) fend = KeyCap;
      write_reg(skc_pkg::CfgFoldCase, 11'($urandom_range(0, 1)));
      write_reg(skc_pkg::CfgDictOrder, 11'($urandom_range(0, 1)));
      write_reg(skc_pkg::CfgFieldStart, 11'(fstart));
      write_reg(skc_pkg::CfgFieldEnd, 11'(fend));
      if ($urandom_range(0, 3) == 0) write_reg(CfgUnused, 11'($urandom_range(0, 2047)));
      repeat ($urandom_range(8, 20)) queue_key_pair();
      wait_until_idle();
    end

    $display("covered %0d load and compare transactions, %0d ignored, %0d config writes",
             key_items, ignored_items, cfg_writes);
    $display("checked %0d compare results, %0d of them with dropped bytes",
             results_checked, overflow_results);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(RunLimit);
    $display("timeout with %0d results still awaited", awaited_diffs.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
